### design/olae_pkg.sv
// ----------------------------------------------------------------------------
// olae_pkg
// Shared codes, field widths and the per-cell control group of the ordered
// array list engine.
// ----------------------------------------------------------------------------
package olae_pkg;

    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 7;
    localparam int S_DATA_W = 40;   // position + value, padded to bytes
    localparam int M_DATA_W = 48;   // read, found, length, empty, padded

    localparam int DEPTH_DEF       = 64;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [OP_W-1:0] OP_GET    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd3;

    typedef struct packed {
        logic ins;      // open a gap at the key and write the value
        logic del;      // close the gap at the key
        logic get;      // match on position rather than on value
    } cell_ctl_t;

endpackage

### design/olae_cell.sv
// ----------------------------------------------------------------------------
// olae_cell
// One list slot: holds an entry, shifts with its neighbours on insert and
// delete, and passes the first-hit token of a lookup one slot per cycle.
// ----------------------------------------------------------------------------
module olae_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8,
    parameter int HW  = 6,
    parameter int SW  = 32
) (
    input  logic               aclk,
    input  olae_pkg::cell_ctl_t ctl_i,
    input  logic [IW-1:0]      key_i,
    input  logic [IW-1:0]      cnt_i,
    input  logic [SW-1:0]      val_i,
    input  logic [SW-1:0]      left_i,
    input  logic [SW-1:0]      right_i,
    output logic [SW-1:0]      data_o,
    input  logic               found_i,
    input  logic [HW-1:0]      idx_i,
    input  logic [SW-1:0]      hit_data_i,
    output logic               found_o,
    output logic [HW-1:0]      idx_o,
    output logic [SW-1:0]      hit_data_o
);
    import olae_pkg::*;

    localparam logic [IW-1:0] MY_POS = IW'(IDX);
    localparam logic [HW-1:0] MY_IDX = HW'(IDX);

    logic [SW-1:0] data_reg, data_next;
    logic          found_reg, found_next;
    logic [HW-1:0] idx_reg, idx_next;
    logic [SW-1:0] hd_reg, hd_next;
    logic          in_list, hit;

    always_comb begin
        data_next = data_reg;
        if (ctl_i.ins) begin
            if (MY_POS > key_i) begin
                data_next = left_i;
            end else if (MY_POS == key_i) begin
                data_next = val_i;
            end
        end else if (ctl_i.del) begin
            if (MY_POS >= key_i) begin
                data_next = right_i;
            end
        end
    end

    assign in_list = MY_POS < cnt_i;
    assign hit     = in_list && (ctl_i.get ? (MY_POS == key_i) : (data_reg == val_i));

    // an earlier hit passes through untouched
    always_comb begin
        found_next = found_i;
        idx_next   = idx_i;
        hd_next    = hit_data_i;
        if (!found_i && hit) begin
            found_next = 1'b1;
            idx_next   = MY_IDX;
            hd_next    = data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        found_reg <= found_next;
        idx_reg   <= idx_next;
        hd_reg    <= hd_next;
    end

    assign data_o     = data_reg;
    assign found_o    = found_reg;
    assign idx_o      = idx_reg;
    assign hit_data_o = hd_reg;

endmodule

### design/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Response: insert and delete answer in the cycle after the beat is taken;
//   get and locate answer once the hit token has run the length of the cell
//   row and been handed into the result register.
// Flow: one item at a time; no beat is taken during a scan or a result stall.
// Reset: aresetn (synchronous, active low) empties the list and drops
//   m_tvalid; entry contents are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
module ordered_array_list_engine #(
    parameter int DEPTH       = olae_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = olae_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [olae_pkg::S_DATA_W-1:0] s_tdata,   // position[6:0], value[38:7]
    input  logic [olae_pkg::OP_W-1:0]     s_tuser,   // operation[1:0]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // read_value[31:0], found_position[38:32], list_length[45:39], is_empty[46]
    output logic [olae_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser    // status[0]
);
    import olae_pkg::*;

    localparam int SW = (VALUE_WIDTH < VAL_W) ? VALUE_WIDTH : VAL_W;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = ((CW > POS_W) ? CW : POS_W) + 1;
    localparam int HW = $clog2(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       tick_reg, tick_next;
    logic [OP_W-1:0]     op_reg;
    logic                bad_reg;
    logic [IW-1:0]       key_reg;
    logic [SW-1:0]       val_reg;

    logic                m_valid_reg, m_valid_next;
    logic                st_reg, st_next;
    logic [VAL_W-1:0]    rd_reg, rd_next;
    logic [LEN_W-1:0]    fp_reg, fp_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic                emp_reg, emp_next;

    logic                s_beat;
    logic [OP_W-1:0]     in_op;
    logic [POS_W-1:0]    in_pos;
    logic [SW-1:0]       in_val;
    logic [IW-1:0]       pos_ext, cnt_ext, in_key;
    logic                bad_rd, bad_ins;

    cell_ctl_t           ctl;
    logic [IW-1:0]       cell_key;
    logic [SW-1:0]       cell_val;

    logic [SW-1:0]       cell_data [DEPTH];
    logic [SW-1:0]       cell_left [DEPTH];
    logic [SW-1:0]       cell_right[DEPTH];
    logic                tok_found [DEPTH+1];
    logic [HW-1:0]       tok_idx   [DEPTH+1];
    logic [SW-1:0]       tok_data  [DEPTH+1];
    logic [HW:0]         hit_pos;

    assign in_op   = s_tuser;
    assign in_pos  = s_tdata[POS_W-1:0];
    assign in_val  = s_tdata[POS_W +: SW];
    assign pos_ext = IW'(in_pos);
    assign cnt_ext = IW'(cnt_reg);
    assign in_key  = pos_ext - IW'(1);

    assign bad_rd  = (in_pos == '0) || (pos_ext > cnt_ext);
    assign bad_ins = (in_pos == '0) || (pos_ext > cnt_ext + IW'(1)) || (cnt_reg == CW'(DEPTH));

    assign s_tready = aresetn && (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign s_beat   = s_tvalid && s_tready;

    // shifts take effect on the accepting edge; lookups run on held copies
    always_comb begin
        ctl.ins  = s_beat && (in_op == OP_INSERT) && !bad_ins;
        ctl.del  = s_beat && (in_op == OP_DELETE) && !bad_rd;
        ctl.get  = (op_reg == OP_GET);
        cell_key = s_beat ? in_key : key_reg;
        cell_val = s_beat ? in_val : val_reg;
    end

    assign tok_found[0] = 1'b0;
    assign tok_idx[0]   = '0;
    assign tok_data[0]  = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign cell_left[g] = cell_data[g];
        end else begin : g_mid
            assign cell_left[g] = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign cell_right[g] = cell_data[g];
        end else begin : g_inner
            assign cell_right[g] = cell_data[g+1];
        end

        olae_cell #(
            .IDX (g),
            .IW  (IW),
            .HW  (HW),
            .SW  (SW)
        ) u_cell (
            .aclk       (aclk),
            .ctl_i      (ctl),
            .key_i      (cell_key),
            .cnt_i      (cnt_ext),
            .val_i      (cell_val),
            .left_i     (cell_left[g]),
            .right_i    (cell_right[g]),
            .data_o     (cell_data[g]),
            .found_i    (tok_found[g]),
            .idx_i      (tok_idx[g]),
            .hit_data_i (tok_data[g]),
            .found_o    (tok_found[g+1]),
            .idx_o      (tok_idx[g+1]),
            .hit_data_o (tok_data[g+1])
        );
    end

    assign hit_pos = {1'b0, tok_idx[DEPTH]} + (HW+1)'(1);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        tick_next    = tick_reg;
        m_valid_next = m_valid_reg && !m_tready;
        st_next      = st_reg;
        rd_next      = rd_reg;
        fp_next      = fp_reg;
        len_next     = len_reg;
        emp_next     = emp_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    case (in_op)
                        OP_INSERT: begin
                            if (!bad_ins) begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                            st_next      = bad_ins;
                            rd_next      = '0;
                            fp_next      = '0;
                            len_next     = LEN_W'(cnt_next);
                            emp_next     = (cnt_next == '0);
                            m_valid_next = 1'b1;
                        end
                        OP_DELETE: begin
                            if (!bad_rd) begin
                                cnt_next = cnt_reg - CW'(1);
                            end
                            st_next      = bad_rd;
                            rd_next      = '0;
                            fp_next      = '0;
                            len_next     = LEN_W'(cnt_next);
                            emp_next     = (cnt_next == '0);
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            tick_next  = '0;
                            state_next = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                tick_next = tick_reg + CW'(1);
                if (tick_reg == CW'(DEPTH)) begin
                    state_next   = ST_IDLE;
                    st_next      = (op_reg == OP_GET) && bad_reg;
                    rd_next      = '0;
                    fp_next      = '0;
                    if (op_reg == OP_GET && !bad_reg && tok_found[DEPTH]) begin
                        rd_next = VAL_W'(tok_data[DEPTH]);
                    end
                    if (op_reg == OP_LOCATE && tok_found[DEPTH]) begin
                        fp_next = LEN_W'(hit_pos);
                    end
                    len_next     = LEN_W'(cnt_reg);
                    emp_next     = (cnt_reg == '0);
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            tick_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            tick_reg    <= tick_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_beat) begin
            op_reg  <= in_op;
            bad_reg <= bad_rd;
            key_reg <= in_key;
            val_reg <= in_val;
        end
        st_reg  <= st_next;
        rd_reg  <= rd_next;
        fp_reg  <= fp_next;
        len_reg <= len_next;
        emp_reg <= emp_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = st_reg;
    assign m_tdata  = M_DATA_W'({emp_reg, len_reg, fp_reg, rd_reg});

endmodule

### design/olae_checker.sv
// ----------------------------------------------------------------------------
// olae_props
// Port-level checks on the result channel of the list engine.
// ----------------------------------------------------------------------------
module olae_props #(
    parameter int DEPTH       = olae_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = olae_pkg::VALUE_WIDTH_DEF
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [olae_pkg::M_DATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import olae_pkg::*;

    localparam bit LEN_EXACT = (DEPTH < 128) && (VALUE_WIDTH > 0);

    // a stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // an error never carries read data
    a_err_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] == '0)
        else $error("error result with read data");

    // empty flag follows the length
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && LEN_EXACT |-> m_tdata[46] == (m_tdata[45:39] == '0))
        else $error("empty flag disagrees with length");

    // a locate hit lies inside the list
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && LEN_EXACT |-> m_tdata[38:32] <= m_tdata[45:39])
        else $error("found position beyond list length");

    // no beat shows both a get value and a locate hit
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:0] == '0) || (m_tdata[38:32] == '0))
        else $error("read value and found position both set");

endmodule

bind ordered_array_list_engine olae_props #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_olae_props (.*);
